/* rtl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_ctrl, sfr_datapath and stream_find_replace; no dependencies.
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = 2'd3;

    // source of an emitted byte
    localparam logic [1:0] EMIT_BUF  = 2'd0;
    localparam logic [1:0] EMIT_REP  = 2'd1;
    localparam logic [1:0] EMIT_BARE = 2'd2;

    typedef struct packed {
        logic       load;       // take the input request into the window
        logic       shift;      // drop the oldest window byte
        logic       clr_cnt;    // window emptied by a match
        logic       rep_start;  // restart replacement byte index
        logic       emit;       // write the output register
        logic [1:0] emit_sel;
        logic       last;
        logic       done;
    } t_cmd;

    typedef struct packed {
        logic pfx;        // window is a prefix of the pattern
        logic pfx_next;   // window without its oldest byte is a prefix
        logic full;       // window length equals pattern length
        logic n_zero;
        logic n_one;
        logic eos;
        logic rlen_zero;
        logic k_last;     // current replacement byte is the last one
        logic slot_free;  // output register can take a result
    } t_sts;

    function automatic logic [3:0] eff_plen(input logic [3:0] len);
        logic [3:0] p;
        p = len;
        if (p == 4'd0) p = 4'd1;
        if (p > 4'(MAX_PATTERN)) p = 4'(MAX_PATTERN);
        return p;
    endfunction

    function automatic logic [3:0] eff_rlen(input logic [3:0] len);
        logic [3:0] r;
        r = len;
        if (r > 4'(MAX_REPLACEMENT)) r = 4'(MAX_REPLACEMENT);
        return r;
    endfunction

endpackage

/* rtl/sfr_ctrl.sv */
// Sequencer for stream find-and-replace: checks, replaces and flushes.
// Depends on sfr_pkg; drives sfr_datapath through t_cmd.
module sfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfr_pkg::t_sts i_sts,
    output sfr_pkg::t_cmd o_cmd
);
    import sfr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_REPL  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.pfx) begin
                    // mismatch: oldest byte leaves as plain data
                    if (i_sts.slot_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_BUF;
                        o_cmd.shift    = 1'b1;
                        o_cmd.last     = i_sts.eos ? i_sts.n_one : i_sts.pfx_next;
                        o_cmd.done     = i_sts.eos & i_sts.n_one;
                        if (o_cmd.last) n_state = ST_IDLE;
                    end
                end else if (i_sts.full) begin
                    if (!i_sts.rlen_zero) begin
                        o_cmd.clr_cnt   = 1'b1;
                        o_cmd.rep_start = 1'b1;
                        n_state         = ST_REPL;
                    end else if (i_sts.eos) begin
                        if (i_sts.slot_free) begin
                            o_cmd.clr_cnt  = 1'b1;
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EMIT_BARE;
                            o_cmd.last     = 1'b1;
                            o_cmd.done     = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end else begin
                        o_cmd.clr_cnt = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (i_sts.eos) begin
                    if (!i_sts.n_zero) begin
                        n_state = ST_FLUSH;
                    end else if (i_sts.slot_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_BARE;
                        o_cmd.last     = 1'b1;
                        o_cmd.done     = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;  // partial prefix held
                end
            end
            ST_REPL: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_REP;
                    o_cmd.last     = i_sts.k_last;
                    o_cmd.done     = i_sts.k_last & i_sts.eos;
                    if (i_sts.k_last) n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_BUF;
                    o_cmd.shift    = 1'b1;
                    o_cmd.last     = i_sts.n_one;
                    o_cmd.done     = i_sts.n_one;
                    if (i_sts.n_one) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_repl_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPL) |-> !i_sts.rlen_zero)
        else $error("replacement sequence with empty replacement");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.done) |-> o_cmd.last)
        else $error("stream end flagged on a non-final result");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (i_sts.eos && !i_sts.n_zero))
        else $error("flush without held bytes or end of stream");

endmodule

/* rtl/sfr_datapath.sv */
// Window, compare logic, configuration registers and output register.
// Depends on sfr_pkg; commanded by sfr_ctrl.
module sfr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfr_pkg::t_cmd               i_cmd,
    output sfr_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_stream,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_stream_done,
    output logic                        o_run_last
);
    import sfr_pkg::*;

    logic [63:0] r_pat;
    logic [3:0]  r_plen;
    logic [63:0] r_rep;
    logic [3:0]  r_rlen;

    logic [7:0]  r_buf [MAX_PATTERN];
    logic [3:0]  r_n;
    logic        r_eos;
    logic [2:0]  r_k;

    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  held;
    logic        pfx;
    logic        pfx_next;
    logic [7:0]  emit_byte;

    assign plen = eff_plen(r_plen);
    assign rlen = eff_rlen(r_rlen);
    assign held = (r_n > plen - 4'd1) ? plen - 4'd1 : r_n;

    always_comb begin
        pfx      = 1'b1;
        pfx_next = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((4'(i) < r_n) && (r_buf[i] != r_pat[8*i +: 8])) pfx = 1'b0;
        end
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            if ((4'(i + 1) < r_n) && (r_buf[i+1] != r_pat[8*i +: 8])) pfx_next = 1'b0;
        end
    end

    assign o_sts.pfx       = pfx;
    assign o_sts.pfx_next  = pfx_next;
    assign o_sts.full      = (r_n == plen);
    assign o_sts.n_zero    = (r_n == 4'd0);
    assign o_sts.n_one     = (r_n == 4'd1);
    assign o_sts.eos       = r_eos;
    assign o_sts.rlen_zero = (rlen == 4'd0);
    assign o_sts.k_last    = ({1'b0, r_k} + 4'd1 == rlen);
    assign o_sts.slot_free = !o_out_valid || !i_out_stall;

    // config registers and held count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= 4'd1;
            r_rep  <= '0;
            r_rlen <= 4'd0;
            r_n    <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PAT_BYTES: r_pat <= i_cfg_data;
                    CFG_PAT_LEN: begin
                        r_plen <= i_cfg_data[3:0];
                        // shorter pattern drops a window it can no longer hold
                        if (eff_plen(i_cfg_data[3:0]) <= r_n) r_n <= 4'd0;
                    end
                    CFG_REP_BYTES: r_rep <= i_cfg_data;
                    CFG_REP_LEN:   r_rlen <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_n <= held + 4'd1;
            end else if (i_cmd.clr_cnt) begin
                r_n <= 4'd0;
            end else if (i_cmd.shift) begin
                r_n <= r_n - 4'd1;
            end
        end
    end

    // window bytes, end flag of the request and replacement byte index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_eos <= i_end_of_stream;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (held == 4'(i)) r_buf[i] <= i_data_byte;
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) r_buf[i] <= r_buf[i+1];
        end
        if (i_cmd.rep_start) begin
            r_k <= 3'd0;
        end else if (i_cmd.emit && i_cmd.emit_sel == EMIT_REP) begin
            r_k <= r_k + 3'd1;
        end
    end

    always_comb begin
        unique case (i_cmd.emit_sel)
            EMIT_BUF: emit_byte = r_buf[0];
            EMIT_REP: emit_byte = r_rep[8*r_k +: 8];
            default:  emit_byte = 8'd0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_byte    <= emit_byte;
            o_byte_valid  <= (i_cmd.emit_sel != EMIT_BARE);
            o_stream_done <= i_cmd.done;
            o_run_last    <= i_cmd.last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 4'(MAX_PATTERN))
        else $error("window count beyond pattern capacity");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result written over a stalled result");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_n != 4'd0))
        else $error("window empty after taking a byte");

endmodule

/* rtl/stream_find_replace.sv */
// Top level of the stream find-and-replace block.
// Depends on sfr_pkg, sfr_ctrl and sfr_datapath.
//
// Replaces every leftmost, non-overlapping occurrence of a 1..8 byte
// pattern in a byte stream by a 0..8 byte replacement; other bytes pass.
// Input channel: i_in_valid / o_in_stall carry one byte plus an end flag.
// Output channel: o_out_valid / i_out_stall carry one result per transfer:
//   o_out_byte, o_byte_valid (0 on a bare end marker), o_stream_done on the
//   final result of the stream, o_run_last on the last result of a request.
// Configuration: i_cfg_we writes register i_cfg_index (0 pattern bytes,
//   1 pattern length, 2 repl. bytes, 3 repl. length); the user must write
//   only while idle, as the block itself does not enforce this.
// Sequencing: an accepted request is loaded into the window and checked;
//   results of a mismatch or a bare end marker leave from the check, while
//   a replacement or an end flush goes on to its own state. The single
//   output register caps the rate at one result a cycle.
// Reset (i_rst_n low, synchronous): window empty, pattern length 1, pattern
//   and replacement zero, replacement length 0, no result pending.
// Stall: a stalled result holds in the output register; the sequencer waits
//   and o_in_stall stays high until the request's results are all written.
module stream_find_replace (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_byte_valid,
    output logic                          o_stream_done,
    output logic                          o_run_last
);
    import sfr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle / check window / replacement bytes / end flush
    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // window, pattern compare, config and the output register
    sfr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_stream_done   (o_stream_done),
        .o_run_last      (o_run_last)
    );

endmodule
